// ===== sv/sbq_pkg.sv =====
// Shared types, constants and coefficient conversion for the selectable biquad filter.
package sbq_pkg;

  // Fraction bits of the delay registers (w values).
  localparam int DELAY_FRAC = 12;

  // Table values are given in units of 1e-8.
  localparam longint DEC_SCALE = 64'sd100000000;

  // Coefficient table: index = filter_kind*16 + rate_select*4 + column,
  // columns are b0, b1, a1, a2 (b2 equals b0, a0 is one).
  localparam longint COEF_DEC [32] = '{
    64'sd6745527,   64'sd13491055,   -64'sd114298050, 64'sd41280160,
    64'sd1335920,   64'sd2671840,    -64'sd164745998, 64'sd70089678,
    64'sd362168,    64'sd724336,     -64'sd182269493, 64'sd83718165,
    64'sd94469,     64'sd188938,     -64'sd191119707, 64'sd91497583,
    64'sd63894553,  -64'sd127789105, -64'sd114298050, 64'sd41280160,
    64'sd83708919,  -64'sd167417838, -64'sd164745998, 64'sd70089678,
    64'sd91496914,  -64'sd182993829, -64'sd182269493, 64'sd83718165,
    64'sd95654323,  -64'sd191308645, -64'sd191119707, 64'sd91497583
  };

  // Coefficient column in the table.
  typedef enum logic [1:0] {
    C_B0 = 2'd0,
    C_B1 = 2'd1,
    C_A1 = 2'd2,
    C_A2 = 2'd3
  } coef_sel_t;

  // Multiplier data operand.
  typedef enum logic [1:0] {
    D_W1 = 2'd0,
    D_W2 = 2'd1,
    D_WN = 2'd2
  } data_sel_t;

  // Command word from controller to datapath.
  typedef struct packed {
    logic      load_x;   // load w accumulator with the scaled input sample
    logic      sub_w;    // subtract product from w accumulator
    logic      latch_w;  // round and saturate w into the new-w register
    logic      load_y;   // load y accumulator with product
    logic      add_y;    // add product to y accumulator
    logic      finish;   // write result register and shift the delays
    coef_sel_t coef_sel;
    data_sel_t data_sel;
  } sbq_cmd_t;

  // Round half away from zero of dec * 2^frac / 1e8.
  function automatic longint to_coef(longint dec, int frac);
    longint mag;
    longint q;
    mag = (dec < 0) ? -dec : dec;
    q = (mag * (longint'(1) << frac) + DEC_SCALE / 2) / DEC_SCALE;
    return (dec < 0) ? -q : q;
  endfunction

endpackage

// ===== sv/sbq_ctrl.sv =====
// Sequencer for the shared multiply-accumulate schedule of the biquad filter.
module sbq_ctrl
  import sbq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output sbq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MA1,
    S_MA2,
    S_MB1,
    S_MB0,
    S_MBW,
    S_SUM,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd          = '0;
    cmd.coef_sel = C_B0;
    cmd.data_sel = D_W1;
    unique case (state)
      S_IDLE: begin
        cmd.load_x = s_tvalid;
      end
      S_MA1: begin
        cmd.coef_sel = C_A1;
        cmd.data_sel = D_W1;
      end
      S_MA2: begin
        cmd.sub_w    = 1'b1;
        cmd.coef_sel = C_A2;
        cmd.data_sel = D_W2;
      end
      S_MB1: begin
        cmd.sub_w    = 1'b1;
        cmd.coef_sel = C_B1;
        cmd.data_sel = D_W1;
      end
      S_MB0: begin
        cmd.latch_w  = 1'b1;
        cmd.load_y   = 1'b1;
        cmd.coef_sel = C_B0;
        cmd.data_sel = D_W2;
      end
      S_MBW: begin
        cmd.add_y    = 1'b1;
        cmd.coef_sel = C_B0;
        cmd.data_sel = D_WN;
      end
      S_SUM: begin
        cmd.add_y = 1'b1;
      end
      S_OUT: begin
        cmd.finish = out_free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // Raise valid when a result is written, drop it once the transaction completes.
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_MA1;
          end
        end
        S_MA1: state <= S_MA2;
        S_MA2: state <= S_MB1;
        S_MB1: state <= S_MB0;
        S_MB0: state <= S_MBW;
        S_MBW: state <= S_SUM;
        S_SUM: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Never overwrite a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while stalled");

  // An accepted sample starts the multiply schedule.
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> state == S_MA1)
    else $error("accepted sample did not start the schedule");

  // A result appears only after a finish command.
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(cmd.finish))
    else $error("output valid without finish");

  // No new sample is taken while the schedule runs.
  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> !s_tready)
    else $error("input ready during schedule");

endmodule

// ===== sv/sbq_dp.sv =====
// Datapath of the biquad filter: coefficient table, shared multiplier, accumulators, delays.
module sbq_dp
  import sbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int DELAY_WIDTH  = 40,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sbq_cmd_t                       cmd,
  input  logic                           clr,
  input  logic                           filter_kind,
  input  logic [1:0]                     rate_select,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           clipped
);

  localparam int CF     = COEF_WIDTH - 2;
  localparam int XSH    = CF + DELAY_FRAC;
  localparam int PROD_W = COEF_WIDTH + DELAY_WIDTH;
  localparam int BIG_W  = (PROD_W > SAMPLE_WIDTH + XSH) ? PROD_W : SAMPLE_WIDTH + XSH;
  localparam int ACC_W  = BIG_W + 3;
  localparam int WS_W   = ACC_W - CF;
  localparam int YS_W   = ACC_W - XSH;

  localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(1) << (CF - 1);
  localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) << (XSH - 1);
  localparam logic signed [DELAY_WIDTH-1:0] W_MAX = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
  localparam logic signed [DELAY_WIDTH-1:0] W_MIN = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0]  coef_rom [32];
  logic signed [COEF_WIDTH-1:0]  mul_a;
  logic signed [DELAY_WIDTH-1:0] mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [ACC_W-1:0]       acc_w;
  logic signed [ACC_W-1:0]       acc_y;
  logic signed [DELAY_WIDTH-1:0] delay_one;
  logic signed [DELAY_WIDTH-1:0] delay_two;
  logic signed [DELAY_WIDTH-1:0] w_new;
  logic signed [ACC_W-1:0]       w_round;
  logic signed [ACC_W-1:0]       y_round;
  logic [WS_W-1:0]               w_shift;
  logic [YS_W-1:0]               y_shift;
  logic [WS_W-DELAY_WIDTH:0]     w_top;
  logic [YS_W-SAMPLE_WIDTH:0]    y_top;
  logic signed [DELAY_WIDTH-1:0] w_sat;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                          y_clip;

  // Constant coefficient table, scaled for this coefficient width.
  for (genvar g = 0; g < 32; g++) begin : g_rom
    assign coef_rom[g] = COEF_WIDTH'(to_coef(COEF_DEC[g], CF));
  end

  assign mul_a = coef_rom[{filter_kind, rate_select, cmd.coef_sel}];

  always_comb begin
    unique case (cmd.data_sel)
      D_W1:    mul_b = delay_one;
      D_W2:    mul_b = delay_two;
      D_WN:    mul_b = w_new;
      default: mul_b = delay_one;
    endcase
  end

  assign prod_ext = ACC_W'(prod);

  // Round half up, drop fraction bits, saturate.
  assign w_round = acc_w + HALF_W;
  assign w_shift = w_round[ACC_W-1:CF];
  assign w_top   = w_shift[WS_W-1:DELAY_WIDTH-1];
  always_comb begin
    if ((&w_top) || !(|w_top)) begin
      w_sat = w_shift[DELAY_WIDTH-1:0];
    end else begin
      w_sat = w_top[WS_W-DELAY_WIDTH] ? W_MIN : W_MAX;
    end
  end

  assign y_round = acc_y + HALF_Y;
  assign y_shift = y_round[ACC_W-1:XSH];
  assign y_top   = y_shift[YS_W-1:SAMPLE_WIDTH-1];
  always_comb begin
    y_clip = !((&y_top) || !(|y_top));
    if (y_clip) begin
      y_sat = y_top[YS_W-SAMPLE_WIDTH] ? Y_MIN : Y_MAX;
    end else begin
      y_sat = y_shift[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load_x) begin
      acc_w <= ACC_W'(sample_in) <<< XSH;
    end else if (cmd.sub_w) begin
      acc_w <= acc_w - prod_ext;
    end
    if (cmd.load_y) begin
      acc_y <= prod_ext;
    end else if (cmd.add_y) begin
      acc_y <= acc_y + prod_ext;
    end
    if (cmd.latch_w) begin
      w_new <= w_sat;
    end
    if (cmd.finish) begin
      sample_out <= y_sat;
      clipped    <= y_clip;
    end
  end

  // Delay line: cleared at reset and on any configuration write.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.finish) begin
      delay_two <= delay_one;
      delay_one <= w_new;
    end
  end

endmodule

// ===== sv/selectable_biquad_iir_filter_unit.sv =====
// Top level of the selectable second-order Butterworth biquad filter unit.
//
// Usage:
//   s_* channel takes one signed sample per transaction; s_tdata carries
//   sample_in in its low SAMPLE_WIDTH bits. m_* channel returns one filtered
//   sample per input transaction; m_tdata carries sample_out, m_tuser carries
//   clipped (set when the result saturated to the sample range).
//   The APB port holds filter_kind (address 0) and rate_select (address 4);
//   together they pick one of eight coefficient sets. Any write clears both
//   delay registers; write only while the filter is idle.
// Timing:
//   Each sample passes through one accept state and seven schedule steps of
//   the single shared multiplier, which forms the five products a1*w1,
//   a2*w2, b1*w1, b0*w2 and b0*w in sequence, before its result appears
//   on m_*. A new sample is accepted only once the previous one has left
//   the multiply schedule; no sample is taken while a schedule runs.
//   If the receiver stalls, the result waits in the output register and the
//   next sample is still accepted and processed; its final step holds until
//   the register frees up.
// Reset: synchronous rst clears both delays, selects lowpass at 100 Hz and
//   empties the output register.
module selectable_biquad_iir_filter_unit
  import sbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int DELAY_WIDTH  = 40,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,   // sample_in, zero pad
  // output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,   // sample_out, zero pad
  output logic                                 m_tuser    // clipped
);

  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  // Register index taken from the word address bit.
  localparam logic REG_FILTER_KIND = 1'b0;
  localparam logic REG_RATE_SELECT = 1'b1;

  logic                           filter_kind;
  logic [1:0]                     rate_select;
  logic                           cfg_wr;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;
  sbq_cmd_t                       cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers; the low address bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_kind <= 1'b0;
      rate_select <= 2'd0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FILTER_KIND: filter_kind <= pwdata[0];
        REG_RATE_SELECT: rate_select <= pwdata[1:0];
      endcase
    end
  end

  // Read back the selected register.
  always_comb begin
    unique case (paddr[2])
      REG_FILTER_KIND: prdata = {31'd0, filter_kind};
      REG_RATE_SELECT: prdata = {30'd0, rate_select};
    endcase
  end

  // Sequence the five products through the shared multiplier.
  sbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Multiply, accumulate, round and hold the delays.
  sbq_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DELAY_WIDTH  (DELAY_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .clr         (cfg_wr),
    .filter_kind (filter_kind),
    .rate_select (rate_select),
    .sample_in   (s_tdata[SAMPLE_WIDTH-1:0]),
    .sample_out  (sample_out),
    .clipped     (clipped)
  );

  // Zero-fill the result up to whole bytes.
  assign m_tdata = TDW'($unsigned(sample_out));
  assign m_tuser = clipped;

endmodule

// ===== test/testbench.sv =====
// Testbench for the selectable biquad filter unit: streamed samples checked against a predictor.
`timescale 1ns / 1ps

typedef logic signed [15:0]  sample_t;
typedef logic signed [39:0]  delay_t;
typedef logic signed [127:0] wide_t;

typedef enum int {
  REG_FILTER_KIND = 0,
  REG_RATE_SELECT = 1
} reg_index_t;

class biquad_scoreboard;
  localparam int COEF_FRAC  = 22;
  localparam int DELAY_FRAC = 12;

  typedef struct {
    sample_t value;
    logic    clip;
  } filtered_t;

  filtered_t  expected_q[$];
  delay_t     w_prev;
  delay_t     w_prev2;
  logic       kind;
  logic [1:0] rate;
  longint     b0, b1, a1, a2;
  int         errors;

  function new();
    kind    = 1'b0;
    rate    = 2'd0;
    w_prev  = '0;
    w_prev2 = '0;
    errors  = 0;
    select_coefficients();
  endfunction

  // Table values are in units of 1e-8; round half away from zero to Q2.22.
  function longint to_fixed(longint units);
    longint mag;
    longint q;
    mag = (units < 0) ? -units : units;
    q = (mag * (longint'(1) << COEF_FRAC) + 64'sd50000000) / 64'sd100000000;
    return (units < 0) ? -q : q;
  endfunction

  function void select_coefficients();
    longint units[4];
    case ({kind, rate})
      3'd0: units = '{6745527, 13491055, -114298050, 41280160};
      3'd1: units = '{1335920, 2671840, -164745998, 70089678};
      3'd2: units = '{362168, 724336, -182269493, 83718165};
      3'd3: units = '{94469, 188938, -191119707, 91497583};
      3'd4: units = '{63894553, -127789105, -114298050, 41280160};
      3'd5: units = '{83708919, -167417838, -164745998, 70089678};
      3'd6: units = '{91496914, -182993829, -182269493, 83718165};
      default: units = '{95654323, -191308645, -191119707, 91497583};
    endcase
    b0 = to_fixed(units[0]);
    b1 = to_fixed(units[1]);
    a1 = to_fixed(units[2]);
    a2 = to_fixed(units[3]);
  endfunction

  // Any register write clears both delays.
  function void set_register(reg_index_t idx, logic [31:0] value);
    if (idx == REG_FILTER_KIND) kind = value[0];
    else rate = value[1:0];
    w_prev  = '0;
    w_prev2 = '0;
    select_coefficients();
  endfunction

  // Round half up: add half an LSB, then floor by arithmetic shift.
  function wide_t round_half_up(wide_t v, int n);
    wide_t half;
    half = wide_t'(1) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function void note_sample(sample_t x);
    wide_t     xs, d1, d2, cb0, cb1, ca1, ca2, acc, w_full, wn, y_full;
    wide_t     w_hi, w_lo, y_hi, y_lo;
    delay_t    w_new;
    filtered_t r;
    xs  = x;
    d1  = w_prev;
    d2  = w_prev2;
    cb0 = b0;
    cb1 = b1;
    ca1 = a1;
    ca2 = a2;
    w_hi = (wide_t'(1) <<< 39) - 1;
    w_lo = -(wide_t'(1) <<< 39);
    y_hi = 32767;
    y_lo = -32768;

    // w = x - a1*w1 - a2*w2, kept exact until rounded to the delay format
    acc = (xs <<< (COEF_FRAC + DELAY_FRAC)) - ca1 * d1 - ca2 * d2;
    w_full = round_half_up(acc, COEF_FRAC);
    if (w_full > w_hi) w_full = w_hi;
    else if (w_full < w_lo) w_full = w_lo;
    w_new = w_full[39:0];
    wn = w_new;

    // y = b0*w + b1*w1 + b0*w2, rounded to an integer and saturated
    acc = cb0 * wn + cb1 * d1 + cb0 * d2;
    y_full = round_half_up(acc, COEF_FRAC + DELAY_FRAC);
    r.clip = 1'b0;
    if (y_full > y_hi) begin
      y_full = y_hi;
      r.clip = 1'b1;
    end else if (y_full < y_lo) begin
      y_full = y_lo;
      r.clip = 1'b1;
    end
    r.value = y_full[15:0];
    expected_q.push_back(r);

    w_prev2 = w_prev;
    w_prev  = w_new;
  endfunction

  function void check_result(sample_t value, logic clip);
    filtered_t r;
    if (expected_q.size() == 0) begin
      $display("%0t: output with none pending: sample_out %0d clipped %0b",
               $time, value, clip);
      errors++;
      return;
    end
    r = expected_q.pop_front();
    if (value !== r.value) begin
      $display("%0t: sample_out mismatch: expected %0d actual %0d",
               $time, r.value, value);
      errors++;
    end
    if (clip !== r.clip) begin
      $display("%0t: clipped mismatch: expected %0b actual %0b", $time, r.clip, clip);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_SAMPLES  = 120;
  localparam int IDLE_PERCENT   = 29;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // sample_in
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // sample_out
  logic        m_tuser;   // clipped

  biquad_scoreboard filter_sb;
  bit      steady;        // suppress idling on both sides
  sample_t walk_level;
  int      stuck_cycles;

  selectable_biquad_iir_filter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Drop the sink's ready at random, 29 percent of the time, except in the steady stretch.
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Check every output transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) filter_sb.check_result(m_tdata, m_tuser);
  end

  // Watchdog: end the run when no transaction moves on either stream for too long.
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Two-phase APB write: setup, then access until pready.
  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    filter_sb.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both registers in random order; upper data bits carry junk that must be masked.
  task automatic configure(input logic kind, input logic [1:0] rate);
    logic [31:0] kind_word;
    logic [31:0] rate_word;
    kind_word = ($urandom & ~32'h1) | 32'(kind);
    rate_word = ($urandom & ~32'h3) | 32'(rate);
    if ($urandom_range(0, 1)) begin
      write_register(REG_FILTER_KIND, kind_word);
      write_register(REG_RATE_SELECT, rate_word);
    end else begin
      write_register(REG_RATE_SELECT, rate_word);
      write_register(REG_FILTER_KIND, kind_word);
    end
  endtask

  // Enter at a rising edge; hold valid until the transaction completes.
  task automatic send_sample(input sample_t x);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    filter_sb.note_sample(x);
  endtask

  // Stop the stream, wait for every pending result, then let the datapath settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (filter_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Styles: full-range noise, slow random walk, rail-to-rail, small values.
  function automatic sample_t pick_sample(input int style);
    int step;
    int next;
    if ($urandom_range(0, 9) == 0) return sample_t'($urandom);
    case (style)
      0: return sample_t'($urandom);
      1: begin
        step = int'($urandom_range(0, 4095)) - 2048;
        next = int'(walk_level) + step;
        if (next > 32767) next = 32767;
        if (next < -32768) next = -32768;
        walk_level = sample_t'(next);
        return walk_level;
      end
      2: return $urandom_range(0, 1) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000);
      default: return sample_t'(int'($urandom_range(0, 256)) - 128);
    endcase
  endfunction

  initial begin
    logic       kind;
    logic [1:0] rate;
    filter_sb  = new();
    steady     = 1'b0;
    walk_level = '0;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset setting (lowpass, 100 Hz) with small values and full-scale steps.
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    repeat (4) send_sample(16'sh7fff);
    repeat (4) send_sample(16'sh8000);
    send_sample(16'sd0);
    drain();

    // Directed: highpass at 1000 Hz with alternating rails to force clipping.
    configure(1'b1, 2'd3);
    for (int i = 0; i < 12; i++) send_sample(i[0] ? sample_t'(16'sh8000) : sample_t'(16'sh7fff));
    drain();

    // Random phases: the first eight walk every coefficient set, the rest pick at random.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 8) begin
        kind = phase[2];
        rate = phase[1:0];
      end else begin
        kind = 1'($urandom_range(0, 1));
        rate = 2'($urandom_range(0, 3));
      end
      configure(kind, rate);
      steady = (phase == 5);
      for (int i = 0; i < PHASE_SAMPLES; i++) send_sample(pick_sample(phase % 4));
      drain();
      steady = 1'b0;
    end

    if (filter_sb.errors == 0 && filter_sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== selectable_biquad_iir_filter_unit.f =====
sv/sbq_pkg.sv
sv/sbq_ctrl.sv
sv/sbq_dp.sv
sv/selectable_biquad_iir_filter_unit.sv
test/testbench.sv
